// ===== hdl/ssd_pkg.sv =====
`timescale 1ns / 1ps

package ssd_pkg;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_WRITE  = 2'd1,
		CMD_INSERT = 2'd2,
		CMD_TICK   = 2'd3
	} cmd_t;

	localparam logic [7:0] SEG_A = 8'h01;
	localparam logic [7:0] SEG_B = 8'h02;
	localparam logic [7:0] SEG_C = 8'h04;
	localparam logic [7:0] SEG_D = 8'h08;
	localparam logic [7:0] SEG_E = 8'h10;
	localparam logic [7:0] SEG_F = 8'h20;
	localparam logic [7:0] SEG_G = 8'h40;
	localparam logic [7:0] SEG_P = 8'h80;

	localparam logic [5:0] CODE_DOT   = 6'd39;
	localparam logic [5:0] CODE_BLANK = 6'd40;

	typedef struct packed {
		logic [7:0] digit_select;
		logic [7:0] segments;
	} scan_t;

	// font lookup, anything past blank is dark
	function automatic logic [7:0] glyph(input logic [5:0] code);
		logic [7:0] g;
		case (code)
			6'd0:  g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
			6'd1:  g = SEG_B | SEG_C;
			6'd2:  g = SEG_A | SEG_B | SEG_D | SEG_E | SEG_G;
			6'd3:  g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_G;
			6'd4:  g = SEG_B | SEG_C | SEG_F | SEG_G;
			6'd5:  g = SEG_A | SEG_C | SEG_D | SEG_F | SEG_G;
			6'd6:  g = SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
			6'd7:  g = SEG_A | SEG_B | SEG_C;
			6'd8:  g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
			6'd9:  g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
			6'd10: g = SEG_A | SEG_B | SEG_C | SEG_E | SEG_F | SEG_G;
			6'd11: g = SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
			6'd12: g = SEG_A | SEG_D | SEG_E | SEG_F;
			6'd13: g = SEG_B | SEG_C | SEG_D | SEG_E | SEG_G;
			6'd14: g = SEG_A | SEG_D | SEG_E | SEG_F | SEG_G;
			6'd15: g = SEG_A | SEG_E | SEG_F | SEG_G;
			6'd16: g = SEG_A | SEG_C | SEG_D | SEG_E | SEG_F;
			6'd17: g = SEG_B | SEG_C | SEG_E | SEG_F | SEG_G;
			6'd18: g = SEG_E | SEG_F;
			6'd19: g = SEG_B | SEG_C | SEG_D | SEG_E;
			6'd20: g = SEG_B | SEG_D | SEG_E | SEG_F | SEG_G;
			6'd21: g = SEG_D | SEG_E | SEG_F;
			6'd22: g = SEG_A | SEG_C | SEG_E | SEG_G;
			6'd23: g = SEG_A | SEG_B | SEG_C | SEG_E | SEG_F;
			6'd24: g = SEG_C | SEG_E | SEG_G;
			6'd25: g = SEG_C | SEG_D | SEG_E | SEG_G;
			6'd26: g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
			6'd27: g = SEG_A | SEG_B | SEG_E | SEG_F | SEG_G;
			6'd28: g = SEG_A | SEG_B | SEG_C | SEG_F | SEG_G;
			6'd29: g = SEG_E | SEG_G;
			6'd30: g = SEG_A | SEG_C | SEG_D | SEG_F | SEG_G;
			6'd31: g = SEG_D | SEG_E | SEG_F | SEG_G;
			6'd32: g = SEG_A | SEG_E | SEG_F;
			6'd33: g = SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
			6'd34: g = SEG_C | SEG_D | SEG_E;
			6'd35: g = SEG_B | SEG_D | SEG_F | SEG_G;
			6'd36: g = SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
			6'd37: g = SEG_A | SEG_B | SEG_D | SEG_E | SEG_G;
			6'd38: g = SEG_G;
			CODE_DOT: g = SEG_P;
			default: g = 8'h00;
		endcase
		return g;
	endfunction

endpackage

// ===== hdl/ssd_if.sv =====
`timescale 1ns / 1ps

interface ssd_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [5:0] char_code;
	logic [2:0] position;

	modport source (output valid, output cmd, output char_code, output position, input ready);
	modport sink   (input valid, input cmd, input char_code, input position, output ready);
endinterface

interface ssd_scan_if;
	logic       valid;
	logic       ready;
	logic [7:0] digit_select;
	logic [7:0] segments;

	modport source (output valid, output digit_select, output segments, input ready);
	modport sink   (input valid, input digit_select, input segments, output ready);
endinterface

// ===== hdl/ssd_buffer.sv =====
`timescale 1ns / 1ps

module ssd_buffer #(
	parameter int NUM_DIGITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  ssd_pkg::cmd_t       cmd,
	input  logic [5:0]          char_code,
	input  logic [2:0]          position,
	output ssd_pkg::scan_t      scan
);

	localparam int PtrW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

	logic [7:0]      buf_q [NUM_DIGITS];
	logic [7:0]      buf_d [NUM_DIGITS];
	logic [PtrW-1:0] ptr_q;
	logic [7:0]      g;
	logic            is_dot;

	assign g      = ssd_pkg::glyph(char_code);
	assign is_dot = (char_code == ssd_pkg::CODE_DOT);

	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			buf_d[i] = buf_q[i];
		end
		case (cmd)
			ssd_pkg::CMD_CLEAR: begin
				for (int i = 0; i < NUM_DIGITS; i++) begin
					buf_d[i] = ssd_pkg::glyph(ssd_pkg::CODE_BLANK);
				end
			end
			ssd_pkg::CMD_WRITE: begin
				// positions beyond the last digit match no entry and are dropped
				for (int i = 0; i < NUM_DIGITS; i++) begin
					if (int'(position) == i) begin
						buf_d[i] = is_dot ? (buf_q[i] | g) : g;
					end
				end
			end
			ssd_pkg::CMD_INSERT: begin
				if (is_dot) begin
					buf_d[0] = buf_q[0] | g;
				end else begin
					for (int i = 1; i < NUM_DIGITS; i++) begin
						buf_d[i] = buf_q[i-1];
					end
					buf_d[0] = g;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DIGITS; i++) begin
				buf_q[i] <= 8'h00;
			end
			ptr_q <= '0;
		end else if (accept) begin
			for (int i = 0; i < NUM_DIGITS; i++) begin
				buf_q[i] <= buf_d[i];
			end
			if (cmd == ssd_pkg::CMD_TICK) begin
				if (ptr_q == PtrW'(NUM_DIGITS - 1)) begin
					ptr_q <= '0;
				end else begin
					ptr_q <= ptr_q + PtrW'(1);
				end
			end
		end
	end

	// digits at or above eight have no select line
	assign scan.digit_select = 8'h01 << ptr_q;
	assign scan.segments     = buf_q[ptr_q];

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(ptr_q) < NUM_DIGITS)
		else $error("scan pointer past last digit");

	a_clear_dark: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd == ssd_pkg::CMD_CLEAR |=> buf_q[0] == 8'h00 && buf_q[NUM_DIGITS-1] == 8'h00)
		else $error("clear left a lit digit");

	a_ptr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && cmd == ssd_pkg::CMD_TICK) |=> $stable(ptr_q))
		else $error("scan pointer moved without a tick");

endmodule

// ===== hdl/ssd_out_stage.sv =====
`timescale 1ns / 1ps

module ssd_out_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  ssd_pkg::scan_t  scan,
	output logic            in_ready,
	ssd_scan_if.source      out
);

	logic           valid_q;
	ssd_pkg::scan_t data_q;

	assign in_ready = !valid_q || out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= scan;
		end
	end

	assign out.valid        = valid_q;
	assign out.digit_select = data_q.digit_select;
	assign out.segments     = data_q.segments;

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> valid_q && data_q == $past(scan))
		else $error("tick result not captured");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> in_ready)
		else $error("result register overwritten while stalled");

endmodule

// ===== hdl/seven_segment_scan_display.sv =====
`timescale 1ns / 1ps
// a tick's scan result is registered, shown in the cycle after the tick is accepted
// throughput: one command per cycle; clear, write and insert finish in the accepting cycle
// a stalled output holds the intake only while the result register is full and not taken
// arst_n clears every digit (display dark), the scan pointer and the output valid

module seven_segment_scan_display #(
	parameter int NUM_DIGITS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	ssd_cmd_if.sink    command,
	ssd_scan_if.source scan
);

	logic           in_ready;
	logic           accept;
	logic           tick;
	ssd_pkg::cmd_t  cmd;
	ssd_pkg::scan_t cur;

	assign cmd           = ssd_pkg::cmd_t'(command.cmd);
	assign command.ready = in_ready;
	assign accept        = command.valid && in_ready;
	assign tick          = accept && (cmd == ssd_pkg::CMD_TICK);

	ssd_buffer #(
		.NUM_DIGITS(NUM_DIGITS)
	) u_buffer (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.cmd       (cmd),
		.char_code (command.char_code),
		.position  (command.position),
		.scan      (cur)
	);

	ssd_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (tick),
		.scan     (cur),
		.in_ready (in_ready),
		.out      (scan)
	);

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	localparam int NUM_DIGITS  = 8;
	localparam int HOLD_CYCLES = 200;
	localparam int DRAIN_LIMIT = 2000;

	localparam logic [5:0] CODE_ZERO        = 6'd0;
	localparam logic [5:0] CODE_EIGHT       = 6'd8;
	localparam logic [5:0] CODE_LAST_LETTER = 6'd37;
	localparam logic [5:0] CODE_MINUS       = 6'd38;
	localparam logic [5:0] CODE_TOP         = 6'd63;

	// character set, indexed by code up to blank
	localparam logic [7:0] FONT [0:40] = '{
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
		8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71,
		8'h3D, 8'h76, 8'h30, 8'h1E, 8'h7A, 8'h38, 8'h55, 8'h37,
		8'h54, 8'h5C, 8'h3F, 8'h73, 8'h67, 8'h50, 8'h6D, 8'h78,
		8'h31, 8'h3E, 8'h1C, 8'h6A, 8'h6E, 8'h5B, 8'h40, 8'h80,
		8'h00
	};

	logic clk = 1'b0;
	logic arst_n;

	ssd_cmd_if  cmd_ch ();
	ssd_scan_if scan_ch ();

	seven_segment_scan_display #(
		.NUM_DIGITS(NUM_DIGITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.command(cmd_ch),
		.scan(scan_ch)
	);

	logic [7:0]     shown_segs [NUM_DIGITS];
	int             scan_ptr;
	ssd_pkg::scan_t scan_expect [$];
	int             mismatches = 0;
	int             send_idle_pct = 0;
	int             recv_idle_pct = 0;
	bit             hold_req = 1'b0;
	int             hold_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic logic [7:0] segs_of(logic [5:0] code);
		return (code <= ssd_pkg::CODE_BLANK) ? FONT[code] : 8'h00;
	endfunction

	// display state update for one accepted item, queues the scan result of a tick
	task automatic apply_command(ssd_pkg::cmd_t c, logic [5:0] code, logic [2:0] pos);
		logic [15:0]    one_hot;
		ssd_pkg::scan_t res;
		case (c)
			ssd_pkg::CMD_CLEAR: begin
				for (int i = 0; i < NUM_DIGITS; i++)
					shown_segs[i] = segs_of(ssd_pkg::CODE_BLANK);
			end
			ssd_pkg::CMD_WRITE: begin
				if (int'(pos) < NUM_DIGITS) begin
					if (code == ssd_pkg::CODE_DOT)
						shown_segs[pos] = shown_segs[pos] | segs_of(code);
					else
						shown_segs[pos] = segs_of(code);
				end
			end
			ssd_pkg::CMD_INSERT: begin
				if (code == ssd_pkg::CODE_DOT) begin
					shown_segs[0] = shown_segs[0] | segs_of(code);
				end else begin
					for (int i = NUM_DIGITS - 1; i > 0; i--)
						shown_segs[i] = shown_segs[i - 1];
					shown_segs[0] = segs_of(code);
				end
			end
			default: begin
				if (scan_ptr >= NUM_DIGITS)
					scan_ptr = 0;
				one_hot = 16'd1 << scan_ptr;
				res.digit_select = one_hot[7:0];
				res.segments = shown_segs[scan_ptr];
				scan_expect.push_back(res);
				scan_ptr++;
				if (scan_ptr >= NUM_DIGITS)
					scan_ptr = 0;
			end
		endcase
	endtask

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(ssd_pkg::cmd_t c, logic [5:0] code, logic [2:0] pos);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid = 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid = 1'b1;
		cmd_ch.cmd = c;
		cmd_ch.char_code = code;
		cmd_ch.position = pos;
		do @(posedge clk); while (!cmd_ch.ready);
		apply_command(c, code, pos);
		@(negedge clk);
		cmd_ch.valid = 1'b0;
	endtask

	function automatic logic [5:0] pick_code();
		int r;
		r = $urandom_range(99);
		if (r < 12)
			return ssd_pkg::CODE_DOT;
		else if (r < 22)
			return 6'($urandom_range(CODE_TOP, ssd_pkg::CODE_BLANK + 1));
		else if (r < 40)
			return 6'($urandom_range(CODE_TOP));
		return 6'($urandom_range(ssd_pkg::CODE_BLANK));
	endfunction

	always @(posedge clk) begin
		ssd_pkg::scan_t want;
		if (arst_n && scan_ch.valid && scan_ch.ready) begin
			if (scan_expect.size() == 0) begin
				$error("scan result %02h/%02h with no tick pending",
					scan_ch.digit_select, scan_ch.segments);
				mismatches++;
			end else begin
				want = scan_expect.pop_front();
				if (scan_ch.digit_select !== want.digit_select) begin
					$error("digit_select: expected %02h, got %02h",
						want.digit_select, scan_ch.digit_select);
					mismatches++;
				end
				if (scan_ch.segments !== want.segments) begin
					$error("segments: expected %02h, got %02h",
						want.segments, scan_ch.segments);
					mismatches++;
				end
			end
		end
	end

	initial begin
		scan_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				scan_ch.ready = 1'b0;
			end else begin
				scan_ch.ready = ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic test_reset_dark();
		repeat (2) send_item(ssd_pkg::CMD_TICK, CODE_ZERO, 3'd0);
	endtask

	task automatic test_edit_ops();
		send_item(ssd_pkg::CMD_WRITE, CODE_ZERO, 3'd0);
		send_item(ssd_pkg::CMD_WRITE, CODE_TOP, 3'd7);
		send_item(ssd_pkg::CMD_WRITE, ssd_pkg::CODE_DOT, 3'd7);
		send_item(ssd_pkg::CMD_WRITE, ssd_pkg::CODE_DOT, 3'd0);
		send_item(ssd_pkg::CMD_INSERT, CODE_MINUS, 3'd5);
		send_item(ssd_pkg::CMD_INSERT, ssd_pkg::CODE_DOT, 3'd2);
		send_item(ssd_pkg::CMD_INSERT, CODE_LAST_LETTER, 3'd7);
		send_item(ssd_pkg::CMD_INSERT, ssd_pkg::CODE_BLANK, 3'd0);
		send_item(ssd_pkg::CMD_WRITE, CODE_EIGHT, 3'd3);
		// pointer sits mid-display here, a full pass wraps it
		repeat (NUM_DIGITS) send_item(ssd_pkg::CMD_TICK, CODE_TOP, 3'd7);
		send_item(ssd_pkg::CMD_CLEAR, CODE_TOP, 3'd7);
		send_item(ssd_pkg::CMD_TICK, CODE_ZERO, 3'd0);
	endtask

	// edit bursts followed by a full scan so every digit is read back
	task automatic test_fill_and_scan(int rounds);
		int edits;
		repeat (rounds) begin
			if ($urandom_range(3) == 0)
				send_item(ssd_pkg::CMD_CLEAR, pick_code(), 3'($urandom_range(7)));
			edits = $urandom_range(10, 2);
			repeat (edits) begin
				if ($urandom_range(1))
					send_item(ssd_pkg::CMD_WRITE, pick_code(), 3'($urandom_range(7)));
				else
					send_item(ssd_pkg::CMD_INSERT, pick_code(), 3'($urandom_range(7)));
			end
			repeat (NUM_DIGITS)
				send_item(ssd_pkg::CMD_TICK, pick_code(), 3'($urandom_range(7)));
		end
	endtask

	task automatic test_random_noise(int count);
		repeat (count)
			send_item(ssd_pkg::cmd_t'($urandom_range(3)), 6'($urandom_range(CODE_TOP)),
				3'($urandom_range(7)));
	endtask

	// output held off while ticks keep coming, intake has to stall
	task automatic test_backpressure(int ticks);
		hold_req = 1'b1;
		@(negedge clk);
		@(negedge clk);
		repeat (ticks) send_item(ssd_pkg::CMD_TICK, pick_code(), 3'($urandom_range(7)));
	endtask

	initial begin
		int waited;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.cmd = ssd_pkg::CMD_CLEAR;
		cmd_ch.char_code = CODE_ZERO;
		cmd_ch.position = 3'd0;
		for (int i = 0; i < NUM_DIGITS; i++)
			shown_segs[i] = 8'h00;
		scan_ptr = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_idle_pct = 33;
		recv_idle_pct = 79;
		test_reset_dark();
		test_edit_ops();
		test_fill_and_scan(17);
		test_random_noise(130);

		send_idle_pct = 79;
		recv_idle_pct = 33;
		test_fill_and_scan(17);
		test_random_noise(130);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_backpressure(40);
		test_fill_and_scan(15);
		test_random_noise(130);

		cmd_ch.valid = 1'b0;
		waited = 0;
		while (scan_expect.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (4) @(negedge clk);
		if (scan_expect.size() != 0) begin
			$error("%0d scan results never arrived", scan_expect.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
